// ----- rtl/btxm_pkg.sv -----
// ----------------------------------------------------------------------------
// btxm_pkg
// Shared constants and types of the binary trie xor-minimum multiset.
// ----------------------------------------------------------------------------
package btxm_pkg;

  localparam int KEY_BITS   = 32;
  localparam int POOL_NODES = 4096;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int USED_W     = $clog2(POOL_NODES + 1);
  localparam int LVL_W      = $clog2(KEY_BITS + 1);
  localparam int BIT_W      = $clog2(KEY_BITS);
  localparam int LINK_W     = 2 * NODE_W;
  localparam int CNT_W      = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_COUNT  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SKIP  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// ----- rtl/btxm_ram.sv -----
// ----------------------------------------------------------------------------
// btxm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module btxm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/binary_trie_xor_min_multiset_top.sv -----
// ----------------------------------------------------------------------------
// binary_trie_xor_min_multiset_top
// Multiset of keys in a bitwise trie with insert, erase, count and
// xor-minimum query.
// ----------------------------------------------------------------------------
// Each trie level takes a read state and a decode state, since both node
// memories have a registered read. A count walks the path once; a query also
// reads the count of the preferred child where that child exists; an insert
// or erase tests presence first and then walks the path again, reading a
// count, writing it back and following or adding a link at each level, to
// update the counts and allocate nodes. The result word is on the out_ ports,
// marked by out_valid for one cycle, in the cycle in which busy falls; the
// receiver cannot stall it. After reset a clearing pass zeroes every node of
// the pool, with busy held high.
// ----------------------------------------------------------------------------
module binary_trie_xor_min_multiset_top
  import btxm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_allow_duplicates,
  output logic        out_valid,
  output logic [31:0] out_multiplicity,
  output logic [31:0] out_min_xor,
  output logic [1:0]  out_status
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PRE, S_RD, S_DEC, S_CRD, S_CDEC, S_DECIDE,
    S_UPD_RD, S_UPD_LINK, S_UPD_CNT, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [NODE_W-1:0]     clr_r, clr_nxt;
  logic                  dup_r, dup_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [NODE_W-1:0]     v_r, v_nxt;
  logic [NODE_W-1:0]     c_r, c_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [USED_W-1:0]     need_r, need_nxt;
  logic                  found_r, found_nxt;
  logic [CNT_W-1:0]      mult_r, mult_nxt;
  logic [KEY_BITS-1:0]   res_r, res_nxt;
  logic [1:0]            stat_r, stat_nxt;
  logic [CNT_W-1:0]      root_r, root_nxt;
  logic [LINK_W-1:0]     links_r, links_nxt;
  logic                  ov_r, ov_nxt;
  logic [31:0]           om_r, om_nxt, ox_r, ox_nxt;
  logic [1:0]            os_r, os_nxt;

  logic                  lk_we, ct_we;
  logic [NODE_W-1:0]     lk_addr, ct_addr;
  logic [LINK_W-1:0]     lk_wdata, lk_rdata;
  logic [CNT_W-1:0]      ct_wdata, ct_rdata;

  btxm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_links (
    .clk(clk), .we(lk_we), .addr(lk_addr), .wdata(lk_wdata), .rdata(lk_rdata)
  );
  btxm_ram #(.WIDTH(CNT_W), .DEPTH(POOL_NODES)) u_counts (
    .clk(clk), .we(ct_we), .addr(ct_addr), .wdata(ct_wdata), .rdata(ct_rdata)
  );

  logic [LVL_W-1:0]  bit_idx;
  logic [BIT_W-1:0]  bit_pos;
  logic              dir;
  logic [NODE_W-1:0] ch, ch_alt;
  logic [NODE_W-1:0] lo, hi;

  assign bit_idx = lvl_r - LVL_W'(1);
  assign bit_pos = bit_idx[BIT_W-1:0];
  assign dir     = key_r[bit_pos];
  assign lo      = lk_rdata[NODE_W-1:0];
  assign hi      = lk_rdata[LINK_W-1:NODE_W];
  assign ch      = dir ? hi : lo;
  assign ch_alt  = dir ? lo : hi;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid        = ov_r;
  assign out_multiplicity = om_r;
  assign out_min_xor      = ox_r;
  assign out_status       = os_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    dup_nxt = dup_r;
    op_nxt = op_r;
    key_nxt = key_r;
    lvl_nxt = lvl_r;
    v_nxt = v_r;
    c_nxt = c_r;
    used_nxt = used_r;
    need_nxt = need_r;
    found_nxt = found_r;
    mult_nxt = mult_r;
    res_nxt = res_r;
    stat_nxt = stat_r;
    root_nxt = root_r;
    links_nxt = links_r;
    ov_nxt = 1'b0;
    om_nxt = om_r;
    ox_nxt = ox_r;
    os_nxt = os_r;
    lk_we = 1'b0;
    ct_we = 1'b0;
    lk_addr = v_r;
    ct_addr = v_r;
    lk_wdata = '0;
    ct_wdata = '0;
    if (cfg_valid) begin
      dup_nxt = cfg_allow_duplicates;
    end
    unique case (state_r)
      S_CLEAR: begin
        lk_we = 1'b1;
        ct_we = 1'b1;
        lk_addr = clr_r;
        ct_addr = clr_r;
        clr_nxt = clr_r + NODE_W'(1);
        if (clr_r == NODE_W'(POOL_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = in_operation;
          key_nxt = in_key[KEY_BITS-1:0];
          lvl_nxt = LVL_W'(KEY_BITS);
          v_nxt = '0;
          mult_nxt = '0;
          res_nxt = '0;
          stat_nxt = ST_DONE;
          found_nxt = 1'b1;
          need_nxt = '0;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        ct_addr = '0;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        root_nxt = ct_rdata;
        if (op_r == OP_QUERY) begin
          if (ct_rdata == '0) begin
            stat_nxt = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        lk_addr = v_r;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (op_r == OP_QUERY) begin
          c_nxt = ch;
          links_nxt = lk_rdata;
          if (ch != '0) begin
            ct_addr = ch;
            state_nxt = S_CDEC;
          end else begin
            res_nxt = res_r | (KEY_BITS'(1) << bit_pos);
            if (ch_alt == '0) begin
              state_nxt = S_DONE;
            end else begin
              v_nxt = ch_alt;
              lvl_nxt = bit_idx;
              state_nxt = (bit_idx == '0) ? S_DONE : S_RD;
            end
          end
        end else if (ch == '0) begin
          found_nxt = 1'b0;
          need_nxt = USED_W'(lvl_r);
          state_nxt = S_DECIDE;
        end else begin
          v_nxt = ch;
          lvl_nxt = bit_idx;
          if (bit_idx == '0) begin
            ct_addr = ch;
            state_nxt = S_CDEC;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_CDEC: begin
        if (op_r == OP_QUERY) begin
          if (ct_rdata != '0) begin
            v_nxt = c_r;
          end else begin
            res_nxt = res_r | (KEY_BITS'(1) << bit_pos);
            v_nxt = dir ? links_r[NODE_W-1:0] : links_r[LINK_W-1:NODE_W];
          end
          if (ct_rdata == '0 &&
              (dir ? links_r[NODE_W-1:0] : links_r[LINK_W-1:NODE_W]) == '0) begin
            state_nxt = S_DONE;
          end else begin
            lvl_nxt = bit_idx;
            state_nxt = (bit_idx == '0) ? S_DONE : S_RD;
          end
        end else begin
          mult_nxt = ct_rdata;
          found_nxt = (ct_rdata != '0);
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        lvl_nxt = LVL_W'(KEY_BITS);
        v_nxt = '0;
        state_nxt = S_DONE;
        unique case (op_r)
          OP_COUNT: begin
            if (!found_r) mult_nxt = '0;
          end
          OP_ERASE: begin
            mult_nxt = '0;
            if (!found_r) stat_nxt = ST_SKIP;
            else state_nxt = S_UPD_CNT;
          end
          OP_INSERT: begin
            mult_nxt = '0;
            if (!dup_r && found_r) begin
              stat_nxt = ST_SKIP;
            end else if (root_r == '1 ||
                         ({1'b0, used_r} + {1'b0, need_r}) >
                         (USED_W + 1)'(POOL_NODES)) begin
              stat_nxt = ST_FULL;
            end else begin
              state_nxt = S_UPD_CNT;
            end
          end
          default: ;
        endcase
        c_nxt = '0;
      end
      S_UPD_CNT: begin
        // The count of node v is read here and written back in the next cycle.
        ct_addr = v_r;
        state_nxt = S_UPD_RD;
      end
      S_UPD_RD: begin
        ct_addr = v_r;
        ct_we = 1'b1;
        ct_wdata = (op_r == OP_INSERT) ? ct_rdata + CNT_W'(1) : ct_rdata - CNT_W'(1);
        if (lvl_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          lk_addr = v_r;
          state_nxt = S_UPD_LINK;
        end
      end
      S_UPD_LINK: begin
        if (ch != '0) begin
          v_nxt = ch;
          lvl_nxt = bit_idx;
          state_nxt = S_UPD_CNT;
        end else begin
          lk_we = 1'b1;
          lk_addr = v_r;
          lk_wdata = dir ? {used_r[NODE_W-1:0], lo} : {hi, used_r[NODE_W-1:0]};
          v_nxt = used_r[NODE_W-1:0];
          used_nxt = used_r + USED_W'(1);
          lvl_nxt = bit_idx;
          state_nxt = S_UPD_CNT;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        om_nxt = mult_r;
        ox_nxt = (stat_r == ST_DONE && op_r == OP_QUERY) ? 32'(res_r) : '0;
        os_nxt = stat_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      dup_r <= 1'b0;
      used_r <= USED_W'(1);
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      dup_r <= dup_nxt;
      used_r <= used_nxt;
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt;
    key_r <= key_nxt;
    lvl_r <= lvl_nxt;
    v_r <= v_nxt;
    c_r <= c_nxt;
    need_r <= need_nxt;
    found_r <= found_nxt;
    mult_r <= mult_nxt;
    res_r <= res_nxt;
    stat_r <= stat_nxt;
    root_r <= root_nxt;
    links_r <= links_nxt;
    om_r <= om_nxt;
    ox_r <= ox_nxt;
    os_r <= os_nxt;
  end

endmodule
